[hdl/bhpq_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and compare function of the binary heap priority queue
package bhpq_pkg;

	localparam int CAPACITY  = 64;
	localparam int KEY_WIDTH = 32;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int IDX_W     = ADDR_W + 2;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic        func;
		logic [31:0] key;
	} in_item_t;

	typedef struct packed {
		logic [31:0] top_key;
		logic        not_empty;
		logic [6:0]  entry_count;
		logic [31:0] removed_key;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    waddr;
		logic [KEY_WIDTH-1:0] wdata;
		logic [ADDR_W-1:0]    raddr_a;
		logic [ADDR_W-1:0]    raddr_b;
	} ram_req_t;

	function automatic logic better(input logic [KEY_WIDTH-1:0] a,
			input logic [KEY_WIDTH-1:0] b, input logic largest_first);
		return largest_first ? (a > b) : (a < b);
	endfunction

endpackage

[hdl/binary_heap_priority_queue.sv]
`timescale 1ns / 1ps
// binary heap priority queue: config register, result register, sequencer and key memory
// a push sifts the new key up level by level; a pop moves the last entry to the root and sifts it down
// items are taken one at a time; the sift loop reads, then compares and writes, at each heap level
// a new item is taken while the previous result still waits in the output register
// reset clears the count, the order setting (smallest first), the sequencer state and the
// output valid flag; the key memory is not cleared
module binary_heap_priority_queue
	import bhpq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	logic                 largest_q;
	logic                 out_valid_q;
	out_item_t            out_q;
	logic                 idle, done, slot_free;
	out_item_t            res;
	ram_req_t             ram_req;
	logic [KEY_WIDTH-1:0] rdata_a, rdata_b;

	assign cfg_ready = 1'b1;
	assign in_ready  = idle;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			largest_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				largest_q <= cfg_data;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	bhpq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_valid && in_ready),
		.item          (in_data),
		.largest_first (largest_q),
		.slot_free     (slot_free),
		.idle          (idle),
		.done          (done),
		.res           (res),
		.ram_req       (ram_req),
		.rdata_a       (rdata_a),
		.rdata_b       (rdata_b)
	);

	bhpq_ram #(
		.WIDTH  (KEY_WIDTH),
		.DEPTH  (CAPACITY),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_req.we),
		.waddr   (ram_req.waddr),
		.wdata   (ram_req.wdata),
		.raddr_a (ram_req.raddr_a),
		.raddr_b (ram_req.raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

endmodule

[hdl/bhpq_ram.sv]
`timescale 1ns / 1ps
// generic memory with one write port and two registered read ports
module bhpq_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WIDTH-1:0]  rdata_a,
	output logic [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[hdl/bhpq_ctrl.sv]
`timescale 1ns / 1ps
// sift sequencer: push and pop over the key memory with a held moving key
module bhpq_ctrl
	import bhpq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  in_item_t             item,
	input  logic                 largest_first,
	input  logic                 slot_free,
	output logic                 idle,
	output logic                 done,
	output out_item_t            res,
	output ram_req_t             ram_req,
	input  logic [KEY_WIDTH-1:0] rdata_a,
	input  logic [KEY_WIDTH-1:0] rdata_b
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LAST   = 3'd1;
	localparam logic [2:0] S_UP_RD  = 3'd2;
	localparam logic [2:0] S_UP_CMP = 3'd3;
	localparam logic [2:0] S_DN_RD  = 3'd4;
	localparam logic [2:0] S_DN_CMP = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0]           state_q, state_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [ADDR_W-1:0]    pos_q, pos_d;
	logic [KEY_WIDTH-1:0] key_q, key_d;
	logic [KEY_WIDTH-1:0] top_q, top_d;
	logic [KEY_WIDTH-1:0] removed_q, removed_d;
	logic [1:0]           status_q, status_d;

	logic [ADDR_W-1:0]    parent;
	logic [IDX_W-1:0]     left, right;
	logic                 right_ok, take_right;
	logic [KEY_WIDTH-1:0] child_key;
	logic [ADDR_W-1:0]    child_pos;

	assign parent     = (pos_q - ADDR_W'(1)) >> 1;
	assign left       = IDX_W'({pos_q, 1'b1});
	assign right      = left + IDX_W'(1);
	assign right_ok   = right < IDX_W'(cnt_q);
	assign take_right = right_ok && better(rdata_b, rdata_a, largest_first);
	assign child_key  = take_right ? rdata_b : rdata_a;
	assign child_pos  = take_right ? right[ADDR_W-1:0] : left[ADDR_W-1:0];

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_FIN) && slot_free;

	always_comb begin
		res.top_key     = (cnt_q != '0) ? top_q : '0;
		res.not_empty   = (cnt_q != '0);
		res.entry_count = cnt_q;
		res.removed_key = removed_q;
		res.status      = status_q;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		key_d     = key_q;
		removed_d = removed_q;
		status_d  = status_q;
		ram_req   = '0;
		case (state_q)
			S_IDLE: begin
				ram_req.raddr_a = ADDR_W'(cnt_q - CNT_W'(1));
				if (start) begin
					removed_d = '0;
					status_d  = STATUS_OK;
					if (item.func == FUNC_PUSH) begin
						if (cnt_q == CNT_W'(CAPACITY)) begin
							status_d = STATUS_FULL;
							state_d  = S_FIN;
						end else begin
							key_d   = item.key;
							pos_d   = cnt_q[ADDR_W-1:0];
							cnt_d   = cnt_q + CNT_W'(1);
							state_d = S_UP_RD;
						end
					end else begin
						if (cnt_q == '0) begin
							status_d = STATUS_EMPTY;
							state_d  = S_FIN;
						end else begin
							removed_d = top_q;
							cnt_d     = cnt_q - CNT_W'(1);
							state_d   = (cnt_q == CNT_W'(1)) ? S_FIN : S_LAST;
						end
					end
				end
			end
			S_LAST: begin
				key_d   = rdata_a;
				pos_d   = '0;
				state_d = S_DN_RD;
			end
			S_UP_RD: begin
				ram_req.raddr_a = parent;
				if (pos_q == '0) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = '0;
					ram_req.wdata = key_q;
					state_d       = S_FIN;
				end else begin
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = pos_q;
				if (better(key_q, rdata_a, largest_first)) begin
					ram_req.wdata = rdata_a;
					pos_d         = parent;
					state_d       = S_UP_RD;
				end else begin
					ram_req.wdata = key_q;
					state_d       = S_FIN;
				end
			end
			S_DN_RD: begin
				ram_req.raddr_a = left[ADDR_W-1:0];
				ram_req.raddr_b = right[ADDR_W-1:0];
				if (left >= IDX_W'(cnt_q)) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = pos_q;
					ram_req.wdata = key_q;
					state_d       = S_FIN;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = pos_q;
				if (better(key_q, child_key, largest_first)) begin
					ram_req.wdata = key_q;
					state_d       = S_FIN;
				end else begin
					ram_req.wdata = child_key;
					pos_d         = child_pos;
					state_d       = S_DN_RD;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// root copy follows every write to entry zero
	assign top_d = (ram_req.we && ram_req.waddr == '0) ? ram_req.wdata : top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		key_q     <= key_d;
		top_q     <= top_d;
		removed_q <= removed_d;
		status_q  <= status_d;
	end

endmodule

[tb/tb_binary_heap_priority_queue.sv]
`timescale 1ns / 1ps
// testbench for the binary heap priority queue: heap predictor, result scoreboard and stimulus
module tb_binary_heap_priority_queue
	import bhpq_pkg::*;
();

	localparam int HOLD_CYCLES = 500;

	class heap_scoreboard;
		logic [KEY_WIDTH-1:0] keys [CAPACITY];
		int unsigned held = 0;
		logic largest_first = 1'b0;
		out_item_t expected_q [$];
		int unsigned errors = 0;
		int unsigned items = 0;
		int unsigned results = 0;
		int unsigned full_pushes = 0;
		int unsigned empty_pops = 0;
		int unsigned deepest = 0;
		int unsigned order_flips = 0;

		function bit outranks(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
			return largest_first ? (a > b) : (a < b);
		endfunction

		function void swap_keys(int unsigned i, int unsigned j);
			logic [KEY_WIDTH-1:0] t;
			t = keys[i];
			keys[i] = keys[j];
			keys[j] = t;
		endfunction

		function void note_item(in_item_t it);
			out_item_t r;
			int unsigned pos, parent, child;
			r = '0;
			r.status = STATUS_OK;
			items++;
			if (it.func == FUNC_PUSH) begin
				if (held >= CAPACITY) begin
					r.status = STATUS_FULL;
					full_pushes++;
				end else begin
					keys[held] = it.key;
					pos = held;
					held++;
					while (pos > 0) begin
						parent = (pos - 1) / 2;
						if (!outranks(keys[pos], keys[parent]))
							break;
						swap_keys(pos, parent);
						pos = parent;
					end
				end
			end else begin
				if (held == 0) begin
					r.status = STATUS_EMPTY;
					empty_pops++;
				end else begin
					r.removed_key = keys[0];
					swap_keys(0, held - 1);
					held--;
					pos = 0;
					while (2 * pos + 1 < held) begin
						child = 2 * pos + 1;
						if (child + 1 < held && outranks(keys[child + 1], keys[child]))
							child++;
						if (outranks(keys[pos], keys[child]))
							break;
						swap_keys(pos, child);
						pos = child;
					end
				end
			end
			if (held > deepest)
				deepest = held;
			r.top_key = (held != 0) ? keys[0] : '0;
			r.not_empty = (held != 0);
			r.entry_count = 7'(held);
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s expected %0h got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				$error("result with no item pending: %h", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			results++;
			compare_field("top_key", want.top_key, got.top_key);
			compare_field("not_empty", 32'(want.not_empty), 32'(got.not_empty));
			compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
			compare_field("removed_key", want.removed_key, got.removed_key);
			compare_field("status", 32'(want.status), 32'(got.status));
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	in_item_t  in_data = '0;
	logic      out_ready = 1'b0;
	logic      cfg_valid = 1'b0;
	logic      cfg_data = 1'b0;
	logic      in_ready;
	logic      out_valid;
	logic      cfg_ready;
	out_item_t out_data;

	heap_scoreboard sb = new;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;

	binary_heap_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("binary_heap_priority_queue: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_item(in_data);
		if (out_valid && out_ready)
			sb.check_result(out_data);
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int serviced_holds;
		serviced_holds = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != serviced_holds) begin
				serviced_holds++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [31:0] pick_key();
		case ($urandom_range(3))
			0: return $urandom_range(15);
			1: return $urandom;
			2: begin
				case ($urandom_range(5))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					3: return 32'h7FFF_FFFF;
					4: return 32'h0000_0001;
					default: return 32'hFFFF_FFFE;
				endcase
			end
			default: return $urandom_range(32'h0001_0000);
		endcase
	endfunction

	task automatic send_item(input logic op, input logic [31:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= in_item_t'{func: op, key: k};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_order(input logic largest);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= largest;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (sb.largest_first != largest && sb.held != 0)
			sb.order_flips++;
		sb.largest_first = largest;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
			1: begin send_idle_pct = 77; recv_stall_pct <= 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct <= 77; end
			default: begin send_idle_pct = 17; recv_stall_pct <= 17; end
		endcase
	endtask

	initial begin
		int push_pct;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, key extremes, duplicates, order change with keys held
		send_item(FUNC_POP, 32'hFFFF_FFFF);
		send_item(FUNC_PUSH, 32'h0000_0000);
		send_item(FUNC_PUSH, 32'hFFFF_FFFF);
		send_item(FUNC_PUSH, 32'h8000_0000);
		send_item(FUNC_PUSH, 32'h7FFF_FFFF);
		send_item(FUNC_PUSH, 32'h0000_0001);
		send_item(FUNC_PUSH, 32'h0000_0001);
		send_item(FUNC_POP, 32'h0000_0000);
		send_item(FUNC_POP, 32'h5555_5555);
		send_item(FUNC_PUSH, 32'h0000_0000);
		write_order(1'b1);
		send_item(FUNC_PUSH, 32'hFFFF_FFFE);
		send_item(FUNC_PUSH, 32'hFFFF_FFFF);
		repeat (8) send_item(FUNC_POP, 32'hAAAA_AAAA);
		write_order(1'b0);

		// long receiver hold-off while pushes are offered; more pushes than capacity, so the last ones find the heap full
		drain();
		set_idling(0);
		hold_requests <= hold_requests + 1;
		repeat (CAPACITY + 8) send_item(FUNC_PUSH, pick_key());

		for (int ph = 0; ph < 8; ph++) begin
			write_order(logic'((ph >> 2) ^ (ph & 1)));
			set_idling(ph % 4);
			for (int i = 0; i < 85; i++) begin
				push_pct = ((i / 30) % 2 == 0) ? 70 : 30;
				if ($urandom_range(99) < push_pct)
					send_item(FUNC_PUSH, pick_key());
				else
					send_item(FUNC_POP, $urandom);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("%0d items, %0d results checked; deepest heap %0d,", sb.items, sb.results,
			sb.deepest);
		$display("%0d full pushes, %0d empty pops, both orderings, %0d order changes with keys held",
			sb.full_pushes, sb.empty_pops, sb.order_flips);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("binary_heap_priority_queue: match");
		else
			$display("binary_heap_priority_queue: mismatch");
		$finish;
	end

endmodule

[filelist.f]
hdl/bhpq_pkg.sv
hdl/bhpq_ram.sv
hdl/bhpq_ctrl.sv
hdl/binary_heap_priority_queue.sv
tb/tb_binary_heap_priority_queue.sv
